### rtl/ile_pkg.sv
// Package for the indexed list engine: store geometry, operation and status
// codes, and the sequencer state type. No dependencies.
`default_nettype none

package ile_pkg;

  localparam int LIST_DEPTH = 256;
  localparam int ELEM_WIDTH = 32;
  localparam int ADDR_W     = $clog2(LIST_DEPTH);
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [ELEM_WIDTH-1:0] elem_t;

  localparam cnt_t DEPTH_CNT = cnt_t'(LIST_DEPTH);

  typedef enum logic [2:0] {
    OP_INSERT   = 3'd0,
    OP_REMOVE   = 3'd1,
    OP_SWAP     = 3'd2,
    OP_MOVE     = 3'd3,
    OP_CONTAINS = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_RANGE = 2'd1,
    STS_FULL  = 2'd2,
    STS_ZERO  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STREAM,
    ST_FINAL,
    ST_SWAP_B,
    ST_SWAP_W1,
    ST_SWAP_W2,
    ST_RESP
  } state_e;

endpackage : ile_pkg

`default_nettype wire

### rtl/indexed_list_engine.sv
// Indexed list engine top level: list store memory, shift/search sequencer
// and result register. Depends on ile_pkg.
`default_nettype none

// An ordered list of up to cap_eff words (the configured capacity, at most
// LIST_DEPTH) held in one single-port-write, single-port-read memory with
// registered read data. One operation is worked on at a time; the input
// stalls until its result has moved into the output register, which may still
// hold an earlier word waiting to be taken. Insert, remove and move walk the
// affected entries as a read stream, one memory read and one write back per
// cycle; contains reads until a match or the last entry, swap reads both
// entries and writes them back crossed, and errors or no-ops go straight to
// the result. The next word is taken in the cycle after the result is
// registered. The single memory write port sets the one-entry-per-cycle walk.
module indexed_list_engine (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           cfg_we_i,
  input  wire  [ile_pkg::CNT_W-1:0]     cfg_wdata_i,
  input  wire                           in_valid_i,
  output logic                          in_stall_o,
  input  wire  [2:0]                    mode_i,
  input  wire  [ile_pkg::CNT_W-1:0]     index_a_i,
  input  wire  [ile_pkg::ADDR_W-1:0]    index_b_i,
  input  wire  [ile_pkg::ELEM_WIDTH-1:0] item_value_i,
  output logic                          out_valid_o,
  input  wire                           out_stall_i,
  output logic [ile_pkg::ELEM_WIDTH-1:0] removed_value_o,
  output logic                          found_o,
  output logic [1:0]                    status_o,
  output logic [ile_pkg::CNT_W-1:0]     entry_count_o,
  output logic                          is_full_o,
  output logic                          is_empty_o
);
  import ile_pkg::*;

  // list store
  elem_t mem [LIST_DEPTH];
  elem_t mem_rdata_q;
  logic  mem_re, mem_we;
  addr_t mem_raddr, mem_waddr;
  elem_t mem_wdata;

  // control
  state_e state_q, state_d;
  cnt_t   count_q, count_d;
  cnt_t   capacity_q;
  logic   rd_active_q, rd_active_d;
  logic   rv_q, rv_d;
  logic   up_q, up_d;
  logic   search_q, search_d;
  logic   capture_q, capture_d;
  logic   final_q, final_d;
  logic   final_t_q, final_t_d;
  logic   out_valid_q, out_valid_d;

  // payload
  addr_t   rd_ptr_q, rd_ptr_d;
  addr_t   rd_end_q, rd_end_d;
  addr_t   raddr_q, raddr_d;
  addr_t   a_q, a_d;
  addr_t   b_q, b_d;
  elem_t   val_q, val_d;
  elem_t   t_q, t_d;
  status_e res_status_q, res_status_d;
  logic    res_found_q, res_found_d;
  logic    res_removed_q, res_removed_d;
  elem_t   out_removed_q, out_removed_d;
  logic    out_found_q, out_found_d;
  status_e out_status_q, out_status_d;
  cnt_t    out_count_q, out_count_d;
  logic    out_full_q, out_full_d;
  logic    out_empty_q, out_empty_d;

  cnt_t  cap_eff;
  cnt_t  cnt_m1;
  cnt_t  ib_cnt;
  addr_t ia_addr;
  logic  val_zero, ia_lt, ib_lt;

  assign cap_eff  = (capacity_q > DEPTH_CNT) ? DEPTH_CNT : capacity_q;
  assign cnt_m1   = count_q - cnt_t'(1);
  assign ib_cnt   = cnt_t'(index_b_i);
  assign ia_addr  = index_a_i[ADDR_W-1:0];
  assign val_zero = (item_value_i == '0);
  assign ia_lt    = (index_a_i < count_q);
  assign ib_lt    = (ib_cnt < count_q);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem[mem_raddr];
    end
  end

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    rd_active_d   = rd_active_q;
    rv_d          = 1'b0;
    up_d          = up_q;
    search_d      = search_q;
    capture_d     = capture_q;
    final_d       = final_q;
    final_t_d     = final_t_q;
    out_valid_d   = out_valid_q;
    rd_ptr_d      = rd_ptr_q;
    rd_end_d      = rd_end_q;
    raddr_d       = raddr_q;
    a_d           = a_q;
    b_d           = b_q;
    val_d         = val_q;
    t_d           = t_q;
    res_status_d  = res_status_q;
    res_found_d   = res_found_q;
    res_removed_d = res_removed_q;
    out_removed_d = out_removed_q;
    out_found_d   = out_found_q;
    out_status_d  = out_status_q;
    out_count_d   = out_count_q;
    out_full_d    = out_full_q;
    out_empty_d   = out_empty_q;
    mem_re        = 1'b0;
    mem_raddr     = rd_ptr_q;
    mem_we        = 1'b0;
    mem_waddr     = a_q;
    mem_wdata     = mem_rdata_q;
    in_stall_o    = (state_q != ST_IDLE);

    // drain the output register independently of the sequencer
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          val_d         = item_value_i;
          a_d           = ia_addr;
          b_d           = index_b_i;
          res_status_d  = STS_OK;
          res_found_d   = 1'b0;
          res_removed_d = 1'b0;
          search_d      = 1'b0;
          capture_d     = 1'b0;
          final_d       = 1'b0;
          final_t_d     = 1'b0;
          up_d          = 1'b0;
          state_d       = ST_RESP;
          case (mode_i)
            OP_INSERT: begin
              if (val_zero) begin
                res_status_d = STS_ZERO;
              end else if (index_a_i > count_q) begin
                res_status_d = STS_RANGE;
              end else if (count_q >= cap_eff) begin
                res_status_d = STS_FULL;
              end else begin
                count_d = count_q + cnt_t'(1);
                final_d = 1'b1;
                if (index_a_i == count_q) begin
                  state_d = ST_FINAL;
                end else begin
                  // walk from the top entry down to the insert point
                  up_d        = 1'b1;
                  rd_ptr_d    = cnt_m1[ADDR_W-1:0];
                  rd_end_d    = ia_addr;
                  rd_active_d = 1'b1;
                  state_d     = ST_STREAM;
                end
              end
            end
            OP_REMOVE: begin
              if (!ia_lt) begin
                res_status_d = STS_RANGE;
              end else begin
                count_d       = cnt_m1;
                res_removed_d = 1'b1;
                capture_d     = 1'b1;
                rd_ptr_d      = ia_addr;
                rd_end_d      = cnt_m1[ADDR_W-1:0];
                rd_active_d   = 1'b1;
                state_d       = ST_STREAM;
              end
            end
            OP_SWAP: begin
              if (!ia_lt || !ib_lt) begin
                res_status_d = STS_RANGE;
              end else if (ia_addr != index_b_i) begin
                mem_re    = 1'b1;
                mem_raddr = ia_addr;
                state_d   = ST_SWAP_B;
              end
            end
            OP_MOVE: begin
              if (!ia_lt || !ib_lt) begin
                res_status_d = STS_RANGE;
              end else if (ia_addr != index_b_i) begin
                // pick up the source word, slide the span, drop it at the target
                capture_d   = 1'b1;
                final_d     = 1'b1;
                final_t_d   = 1'b1;
                up_d        = (ia_addr > index_b_i);
                rd_ptr_d    = ia_addr;
                rd_end_d    = index_b_i;
                rd_active_d = 1'b1;
                state_d     = ST_STREAM;
              end
            end
            OP_CONTAINS: begin
              if (val_zero) begin
                res_status_d = STS_ZERO;
              end else if (count_q != '0) begin
                search_d    = 1'b1;
                rd_ptr_d    = '0;
                rd_end_d    = cnt_m1[ADDR_W-1:0];
                rd_active_d = 1'b1;
                state_d     = ST_STREAM;
              end
            end
            default: begin
              res_status_d = STS_OK;
            end
          endcase
        end
      end

      ST_STREAM: begin
        if (rd_active_q) begin
          mem_re      = 1'b1;
          mem_raddr   = rd_ptr_q;
          rv_d        = 1'b1;
          raddr_d     = rd_ptr_q;
          rd_active_d = (rd_ptr_q != rd_end_q);
          rd_ptr_d    = up_q ? (rd_ptr_q - addr_t'(1)) : (rd_ptr_q + addr_t'(1));
        end
        if (rv_q) begin
          if (search_q) begin
            if (mem_rdata_q == val_q) begin
              res_found_d = 1'b1;
              rd_active_d = 1'b0;
              rv_d        = 1'b0;
              state_d     = ST_RESP;
            end
          end else if (capture_q && (raddr_q == a_q)) begin
            t_d = mem_rdata_q;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = up_q ? (raddr_q + addr_t'(1)) : (raddr_q - addr_t'(1));
            mem_wdata = mem_rdata_q;
          end
        end
        if (!rd_active_q && !rv_q) begin
          state_d = final_q ? ST_FINAL : ST_RESP;
        end
      end

      ST_FINAL: begin
        mem_we    = 1'b1;
        mem_waddr = final_t_q ? b_q : a_q;
        mem_wdata = final_t_q ? t_q : val_q;
        state_d   = ST_RESP;
      end

      ST_SWAP_B: begin
        mem_re    = 1'b1;
        mem_raddr = b_q;
        t_d       = mem_rdata_q;
        state_d   = ST_SWAP_W1;
      end

      ST_SWAP_W1: begin
        mem_we    = 1'b1;
        mem_waddr = a_q;
        mem_wdata = mem_rdata_q;
        state_d   = ST_SWAP_W2;
      end

      ST_SWAP_W2: begin
        mem_we    = 1'b1;
        mem_waddr = b_q;
        mem_wdata = t_q;
        state_d   = ST_RESP;
      end

      ST_RESP: begin
        // hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d   = 1'b1;
          out_removed_d = res_removed_q ? t_q : '0;
          out_found_d   = res_found_q;
          out_status_d  = res_status_q;
          out_count_d   = count_q;
          out_full_d    = (count_q >= cap_eff);
          out_empty_d   = (count_q == '0);
          state_d       = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      capacity_q  <= DEPTH_CNT;
      rd_active_q <= 1'b0;
      rv_q        <= 1'b0;
      up_q        <= 1'b0;
      search_q    <= 1'b0;
      capture_q   <= 1'b0;
      final_q     <= 1'b0;
      final_t_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rd_active_q <= rd_active_d;
      rv_q        <= rv_d;
      up_q        <= up_d;
      search_q    <= search_d;
      capture_q   <= capture_d;
      final_q     <= final_d;
      final_t_q   <= final_t_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        capacity_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_ptr_q      <= rd_ptr_d;
    rd_end_q      <= rd_end_d;
    raddr_q       <= raddr_d;
    a_q           <= a_d;
    b_q           <= b_d;
    val_q         <= val_d;
    t_q           <= t_d;
    res_status_q  <= res_status_d;
    res_found_q   <= res_found_d;
    res_removed_q <= res_removed_d;
    out_removed_q <= out_removed_d;
    out_found_q   <= out_found_d;
    out_status_q  <= out_status_d;
    out_count_q   <= out_count_d;
    out_full_q    <= out_full_d;
    out_empty_q   <= out_empty_d;
  end

  assign out_valid_o     = out_valid_q;
  assign removed_value_o = out_removed_q;
  assign found_o         = out_found_q;
  assign status_o        = out_status_q;
  assign entry_count_o   = out_count_q;
  assign is_full_o       = out_full_q;
  assign is_empty_o      = out_empty_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DEPTH_CNT)
    else $error("list count exceeds store depth");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE || state_q == ST_RESP) |-> !mem_we)
    else $error("store written outside an operation");

  a_read_in_stream: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rv_q |-> (state_q == ST_STREAM))
    else $error("read data pending outside the entry walk");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_empty_q == (out_count_q == '0)))
    else $error("empty flag disagrees with reported count");

  a_count_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |=> $stable(count_q))
    else $error("count changed while an operation was in progress");
`endif

endmodule : indexed_list_engine

`default_nettype wire
